/* hdl/lbfc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and helpers of the bounded frequency counter.
package lbfc_pkg;

    localparam int COUNT_W = 32;
    localparam int NODE_W  = 32;
    localparam int BLOCK_W = 64;
    localparam int OCC_W   = 7;
    localparam int CAP_W   = 7;
    localparam int KIND_W  = 2;

    localparam logic [KIND_W-1:0] KIND_OBSERVE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE  = 2'd2;

    localparam logic [CAP_W-1:0]   CAP_RESET = 7'd64;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        UPD_TOUCH,
        UPD_INSERT,
        UPD_DROP
    } upd_mode_t;

    typedef struct packed {
        logic [NODE_W-1:0]  node;
        logic [BLOCK_W-1:0] block;
    } key_t;

    typedef struct packed {
        logic               valid;
        logic [NODE_W-1:0]  node;
        logic [BLOCK_W-1:0] block;
        logic [COUNT_W-1:0] count;
    } entry_t;

    typedef struct packed {
        logic [OCC_W-1:0]   occupancy;
        logic [COUNT_W-1:0] count;
        logic               hit;
    } result_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
    endfunction

endpackage

/* hdl/lbfc_table.sv */
`timescale 1ns / 1ps
// Entry memory with one write port and one registered read port.
module lbfc_table
    import lbfc_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int IW    = 6,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [IW-1:0] rd_addr,
    output entry_t        rd_entry,
    output logic [AW-1:0] rd_age,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_addr,
    input  entry_t        wr_entry,
    input  logic [AW-1:0] wr_age
);

    localparam int WORD_W = $bits(entry_t) + AW;

    logic [WORD_W-1:0] entry_mem [DEPTH];
    logic [WORD_W-1:0] rd_word_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= {wr_age, wr_entry};
        end
        if (rd_en) begin
            rd_word_reg <= entry_mem[rd_addr];
        end
    end

    assign {rd_age, rd_entry} = rd_word_reg;

endmodule

/* hdl/lbfc_entry_unit.sv */
`timescale 1ns / 1ps
// Shared per-entry unit: key compare during the search pass, entry rewrite during the update pass.
module lbfc_entry_unit
    import lbfc_pkg::*;
#(
    parameter int ENTRIES = 64,
    parameter int IW      = 6,
    parameter int AW      = 6
) (
    input  entry_t        rd_entry,
    input  logic [AW-1:0] rd_age,
    input  logic [IW-1:0] rd_idx,
    input  key_t          key,
    input  upd_mode_t     mode,
    input  logic [IW-1:0] hit_slot,
    input  logic [AW-1:0] hit_age,
    input  logic [IW-1:0] ins_slot,
    input  logic [AW:0]   cap_eff,
    output logic          match,
    output logic          empty,
    output logic          eldest,
    output logic          wr_en,
    output entry_t        wr_entry,
    output logic [AW-1:0] wr_age
);

    logic [AW:0] age_up;

    assign match  = rd_entry.valid && (rd_entry.node == key.node)
                    && (rd_entry.block == key.block);
    assign empty  = !rd_entry.valid;
    assign eldest = rd_entry.valid && (rd_age == AW'(ENTRIES - 1));
    assign age_up = {1'b0, rd_age} + (AW + 1)'(1);

    always_comb begin
        wr_en    = 1'b0;
        wr_entry = rd_entry;
        wr_age   = rd_age;
        case (mode)
            UPD_TOUCH: begin
                if (rd_idx == hit_slot) begin
                    wr_en          = 1'b1;
                    wr_entry.count = sat_inc(rd_entry.count);
                    wr_age         = '0;
                end else if (rd_entry.valid && (rd_age < hit_age)) begin
                    wr_en  = 1'b1;
                    wr_age = age_up[AW-1:0];
                end
            end
            UPD_INSERT: begin
                if (rd_idx == ins_slot) begin
                    wr_en          = 1'b1;
                    wr_entry.valid = (cap_eff != '0);
                    wr_entry.node  = key.node;
                    wr_entry.block = key.block;
                    wr_entry.count = COUNT_W'(1);
                    wr_age         = '0;
                end else if (rd_entry.valid) begin
                    wr_en          = 1'b1;
                    wr_entry.valid = (age_up < cap_eff);
                    wr_age         = age_up[AW-1:0];
                end
            end
            UPD_DROP: begin
                if (rd_idx == hit_slot) begin
                    wr_en          = 1'b1;
                    wr_entry.valid = 1'b0;
                end else if (rd_entry.valid && (rd_age > hit_age)) begin
                    wr_en  = 1'b1;
                    wr_age = rd_age - AW'(1);
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

endmodule

/* hdl/lbfc_seq.sv */
`timescale 1ns / 1ps
// Sequencer that walks the entry memory through the clear, search and update passes.
module lbfc_seq
    import lbfc_pkg::*;
#(
    parameter int ENTRIES = 64,
    parameter int IW      = 6,
    parameter int AW      = 6,
    parameter int CW      = 7
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [KIND_W-1:0]  in_kind,
    input  logic               in_present,
    input  key_t               in_key,
    input  logic [CAP_W-1:0]   capacity,
    output logic               res_valid,
    input  logic               res_ready,
    output result_t            res
);

    localparam int SW = AW + 1;
    localparam int XW = (SW > CAP_W) ? SW : CAP_W;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_SEARCH = 7'b0000100,
        ST_SDRAIN = 7'b0001000,
        ST_UPDATE = 7'b0010000,
        ST_UDRAIN = 7'b0100000,
        ST_RESULT = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [IW-1:0]       rd_idx_reg, rd_idx_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    key_t                key_reg, key_next;
    logic                active_reg, active_next;
    logic                hit_reg, hit_next;
    logic [IW-1:0]       slot_reg, slot_next;
    logic [AW-1:0]       age_a_reg, age_a_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                free_found_reg, free_found_next;
    logic [IW-1:0]       free_slot_reg, free_slot_next;
    logic [IW-1:0]       eldest_slot_reg, eldest_slot_next;
    logic [CW-1:0]       used_reg, used_next;

    logic                idx_last;
    logic                rd_en;
    logic [IW-1:0]       rd_addr;
    entry_t              rd_entry;
    logic [AW-1:0]       rd_age;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    entry_t              wr_entry;
    logic [AW-1:0]       wr_age;

    upd_mode_t           mode;
    logic                table_full;
    logic [IW-1:0]       ins_slot;
    logic [XW-1:0]       cap_x;
    logic [SW-1:0]       cap_eff;
    logic [CW-1:0]       used_ins;
    logic [SW-1:0]       occ_ins;
    logic [CW-1:0]       occ_after;
    logic                unit_match;
    logic                unit_empty;
    logic                unit_eldest;
    logic                unit_wr_en;
    entry_t              unit_entry;
    logic [AW-1:0]       unit_age;

    lbfc_table #(
        .DEPTH (ENTRIES),
        .IW    (IW),
        .AW    (AW)
    ) u_table (
        .aclk     (aclk),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .rd_age   (rd_age),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .wr_age   (wr_age)
    );

    lbfc_entry_unit #(
        .ENTRIES (ENTRIES),
        .IW      (IW),
        .AW      (AW)
    ) u_unit (
        .rd_entry (rd_entry),
        .rd_age   (rd_age),
        .rd_idx   (rd_idx_reg),
        .key      (key_reg),
        .mode     (mode),
        .hit_slot (slot_reg),
        .hit_age  (age_a_reg),
        .ins_slot (ins_slot),
        .cap_eff  (cap_eff),
        .match    (unit_match),
        .empty    (unit_empty),
        .eldest   (unit_eldest),
        .wr_en    (unit_wr_en),
        .wr_entry (unit_entry),
        .wr_age   (unit_age)
    );

    assign idx_last   = (idx_reg == IW'(ENTRIES - 1));
    assign table_full = (used_reg == CW'(ENTRIES));
    assign ins_slot   = table_full ? eldest_slot_reg : free_slot_reg;
    assign cap_x      = XW'(capacity);
    assign cap_eff    = (cap_x < XW'(ENTRIES)) ? SW'(cap_x) : SW'(ENTRIES);
    assign used_ins   = table_full ? used_reg : used_reg + CW'(1);
    assign occ_ins    = (SW'(used_ins) < cap_eff) ? SW'(used_ins) : cap_eff;

    always_comb begin
        if (kind_reg == KIND_OBSERVE) begin
            mode = hit_reg ? UPD_TOUCH : UPD_INSERT;
        end else begin
            mode = UPD_DROP;
        end
    end

    always_comb begin
        occ_after = used_reg;
        if (active_reg) begin
            if ((kind_reg == KIND_OBSERVE) && !hit_reg) begin
                occ_after = CW'(occ_ins);
            end else if ((kind_reg == KIND_REMOVE) && hit_reg) begin
                occ_after = used_reg - CW'(1);
            end
        end
    end

    always_comb begin
        res.hit       = hit_reg;
        res.occupancy = OCC_W'(occ_after);
        res.count     = '0;
        if (active_reg) begin
            if (kind_reg == KIND_OBSERVE) begin
                res.count = hit_reg ? sat_inc(count_reg) : COUNT_W'(1);
            end else if ((kind_reg == KIND_QUERY) && hit_reg) begin
                res.count = count_reg;
            end
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESULT);

    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        kind_next        = kind_reg;
        key_next         = key_reg;
        active_next      = active_reg;
        hit_next         = hit_reg;
        slot_next        = slot_reg;
        age_a_next       = age_a_reg;
        count_next       = count_reg;
        free_found_next  = free_found_reg;
        free_slot_next   = free_slot_reg;
        eldest_slot_next = eldest_slot_reg;
        used_next        = used_reg;
        rd_en            = 1'b0;
        rd_addr          = idx_reg;
        wr_en            = 1'b0;
        wr_addr          = rd_idx_reg;
        wr_entry         = unit_entry;
        wr_age           = unit_age;

        if (rd_pend_reg && ((state_reg == ST_SEARCH) || (state_reg == ST_SDRAIN))) begin
            if (unit_match) begin
                hit_next   = 1'b1;
                slot_next  = rd_idx_reg;
                age_a_next = rd_age;
                count_next = rd_entry.count;
            end
            if (unit_empty && !free_found_reg) begin
                free_found_next = 1'b1;
                free_slot_next  = rd_idx_reg;
            end
            if (unit_eldest) begin
                eldest_slot_next = rd_idx_reg;
            end
        end

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                wr_entry = '0;
                wr_age   = '0;
                idx_next = idx_last ? '0 : idx_reg + IW'(1);
                if (idx_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_valid) begin
                    kind_next       = in_kind;
                    key_next        = in_key;
                    active_next     = in_present && ((in_kind == KIND_OBSERVE)
                                      || (in_kind == KIND_QUERY)
                                      || (in_kind == KIND_REMOVE));
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    idx_next        = '0;
                    state_next      = active_next ? ST_SEARCH : ST_RESULT;
                end
            end
            ST_SEARCH: begin
                rd_en    = 1'b1;
                idx_next = idx_last ? '0 : idx_reg + IW'(1);
                if (idx_last) begin
                    state_next = ST_SDRAIN;
                end
            end
            ST_SDRAIN: begin
                if ((kind_reg == KIND_OBSERVE) || ((kind_reg == KIND_REMOVE) && hit_next)) begin
                    state_next = ST_UPDATE;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_UPDATE: begin
                rd_en    = 1'b1;
                wr_en    = rd_pend_reg && unit_wr_en;
                idx_next = idx_last ? '0 : idx_reg + IW'(1);
                if (idx_last) begin
                    state_next = ST_UDRAIN;
                end
            end
            ST_UDRAIN: begin
                wr_en      = rd_pend_reg && unit_wr_en;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (res_ready) begin
                    used_next  = occ_after;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
                idx_next   = '0;
            end
        endcase

        rd_pend_next = rd_en;
        rd_idx_next  = rd_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            idx_reg     <= '0;
            rd_pend_reg <= 1'b0;
            used_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            rd_pend_reg <= rd_pend_next;
            used_reg    <= used_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg      <= rd_idx_next;
        kind_reg        <= kind_next;
        key_reg         <= key_next;
        active_reg      <= active_next;
        hit_reg         <= hit_next;
        slot_reg        <= slot_next;
        age_a_reg       <= age_a_next;
        count_reg       <= count_next;
        free_found_reg  <= free_found_next;
        free_slot_reg   <= free_slot_next;
        eldest_slot_reg <= eldest_slot_next;
    end

endmodule

/* hdl/lru_bounded_frequency_counter.sv */
`timescale 1ns / 1ps
// Bounded table of access counters kept in recency order, with a stream in, a stream out
// and a register port.
//
// Each item on the s_ channel is an observe, query or remove request keyed by a caller
// node and a block key. The m_ channel returns one result item per request: the hit flag,
// the count and the table occupancy after the request. The register port holds the
// capacity at byte address 0. It should only be written while no item is in flight.
//
// Every request is worked through by one sequencer that reads the entry memory one entry a
// cycle. A query or a remove that misses makes one search pass over the memory, observe
// requests and remove hits make a search pass and an update pass, and an item with no
// caller or an unused kind skips both passes. s_tready is high only between items.
//
// After reset a clearing pass over all entries marks them empty, and s_tready stays low
// until it ends. The capacity resets to 64. A finished result waits in an output
// register; the next item is accepted while it waits, and a stalled receiver holds back
// the hand-over of the following result and with it the acceptance of further items.
module lru_bounded_frequency_counter
    import lbfc_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // caller_node, block_id
    input  logic [2:0]  s_tuser,   // kind, caller_present
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // hit, count, occupancy
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IW = AW;
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic REG_CAPACITY = 1'b0;

    logic [CAP_W-1:0] capacity_reg;
    logic             cfg_write;
    logic             res_valid;
    logic             res_ready;
    result_t          res;
    logic             m_valid_reg;
    result_t          m_data_reg;
    key_t             in_key;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
    assign prdata    = (paddr[2] == REG_CAPACITY) ? 32'(capacity_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (cfg_write) begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign in_key.node  = s_tdata[31:0];
    assign in_key.block = s_tdata[95:32];

    lbfc_seq #(
        .ENTRIES (ENTRIES),
        .IW      (IW),
        .AW      (AW),
        .CW      (CW)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_kind    (s_tuser[1:0]),
        .in_present (s_tuser[2]),
        .in_key     (in_key),
        .capacity   (capacity_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
